// ===== rtl/greedy_note_dispenser_assert.svh =====
// Assertion macros used by the dispenser checker
`ifndef GREEDY_NOTE_DISPENSER_ASSERT_SVH
`define GREEDY_NOTE_DISPENSER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define GND_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("greedy_note_dispenser: assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define GND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("greedy_note_dispenser: assertion failed");

`endif

// ===== rtl/gnd_pkg.sv =====
// Package of the note dispenser: widths, note tables, status codes and control types
package gnd_pkg;

  localparam int unsigned AMOUNT_W            = 18;
  localparam int unsigned COUNT_W             = 14;
  localparam int unsigned STATUS_W            = 2;
  localparam int unsigned VALUE_W             = 9;
  localparam int unsigned TABLE_SIZE          = 8;
  localparam int unsigned TBL_IDX_W           = 3;
  localparam int unsigned NUM_NOTE_VALUES_DEF = 8;

  // quotient by multiplication: q = (x * ceil(2^27 / v)) >> 27, exact for 18-bit x, v <= 450
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned PROD_W      = AMOUNT_W + RECIP_W;
  localparam int unsigned NV_W        = COUNT_W + VALUE_W;

  localparam logic [VALUE_W-1:0] NOTE_VALUE [TABLE_SIZE] = '{
    9'd1, 9'd2, 9'd5, 9'd10, 9'd20, 9'd50, 9'd250, 9'd450
  };

  localparam logic [RECIP_W-1:0] NOTE_RECIP [TABLE_SIZE] = '{
    28'd134217728, 28'd67108864, 28'd26843546, 28'd13421773,
    28'd6710887,   28'd2684355,  28'd536871,   28'd298262
  };

  localparam logic [COUNT_W-1:0] STOCK_RESET [TABLE_SIZE] = '{
    14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400, 14'd200, 14'd100
  };

  localparam logic [STATUS_W-1:0] ST_DISPENSED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_QUOTED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CANNOT    = 2'd3;

  typedef struct packed {
    logic                load;
    logic                mul;
    logic                clamp;
    logic                sub;
    logic                publish;
    logic                debit;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic rest_zero;
    logic amount_zero;
    logic commit;
  } sts_t;

endpackage

// ===== rtl/gnd_req_if.sv =====
// Request channel of the note dispenser: amount and commit flag
interface gnd_req_if;
  logic                         valid;
  logic                         ready;
  logic [gnd_pkg::AMOUNT_W-1:0] amount;
  logic                         commit;

  modport source (output valid, output amount, output commit, input ready);
  modport sink   (input valid, input amount, input commit, output ready);
endinterface

// ===== rtl/gnd_rsp_if.sv =====
// Result channel of the note dispenser: status and note counts
interface gnd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [gnd_pkg::STATUS_W-1:0] status;
  logic [gnd_pkg::COUNT_W-1:0]  notes_450;
  logic [gnd_pkg::COUNT_W-1:0]  notes_250;
  logic [gnd_pkg::COUNT_W-1:0]  notes_50;
  logic [gnd_pkg::COUNT_W-1:0]  notes_20;
  logic [gnd_pkg::COUNT_W-1:0]  notes_10;
  logic [gnd_pkg::COUNT_W-1:0]  notes_5;
  logic [gnd_pkg::COUNT_W-1:0]  notes_2;
  logic [gnd_pkg::COUNT_W-1:0]  notes_1;

  modport source (
    output valid, output status,
    output notes_450, output notes_250, output notes_50, output notes_20,
    output notes_10, output notes_5, output notes_2, output notes_1,
    input ready
  );
  modport sink (
    input valid, input status,
    input notes_450, input notes_250, input notes_50, input notes_20,
    input notes_10, input notes_5, input notes_2, input notes_1,
    output ready
  );
endinterface

// ===== rtl/gnd_datapath.sv =====
// Datapath of the note dispenser: remainder, quotient, clamp, stock and result registers
module gnd_datapath #(
  parameter int unsigned NUM_USED = gnd_pkg::TABLE_SIZE
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic [gnd_pkg::AMOUNT_W-1:0]                           amount_i,
  input  logic                                                   commit_i,
  input  gnd_pkg::cmd_t                                          cmd_i,
  output gnd_pkg::sts_t                                          sts_o,
  output logic [gnd_pkg::STATUS_W-1:0]                           status_o,
  output logic [gnd_pkg::TABLE_SIZE-1:0][gnd_pkg::COUNT_W-1:0]   notes_o
);

  localparam int unsigned IDX_W = (NUM_USED > 1) ? $clog2(NUM_USED) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUM_USED - 1);

  logic [gnd_pkg::AMOUNT_W-1:0]  rest_q;
  logic [gnd_pkg::AMOUNT_W-1:0]  quot_q;
  logic [gnd_pkg::NV_W-1:0]      nv_q;
  logic [IDX_W-1:0]              idx_q;
  logic                          commit_q;
  logic                          zero_q;
  logic [gnd_pkg::COUNT_W-1:0]   chosen_q [NUM_USED];
  logic [gnd_pkg::COUNT_W-1:0]   stock_q  [NUM_USED];
  logic [gnd_pkg::STATUS_W-1:0]  status_q;
  logic [gnd_pkg::TABLE_SIZE-1:0][gnd_pkg::COUNT_W-1:0] notes_q;

  logic [gnd_pkg::TBL_IDX_W-1:0] tbl_idx;
  logic [gnd_pkg::VALUE_W-1:0]   value;
  logic [gnd_pkg::RECIP_W-1:0]   recip;
  logic [gnd_pkg::PROD_W-1:0]    prod;
  logic [gnd_pkg::COUNT_W-1:0]   stock_sel;
  logic [gnd_pkg::COUNT_W-1:0]   take;
  logic [gnd_pkg::NV_W-1:0]      nv;
  logic                          clear_counts;
  logic [gnd_pkg::TABLE_SIZE-1:0][gnd_pkg::COUNT_W-1:0] chosen_full;

  assign tbl_idx   = gnd_pkg::TBL_IDX_W'(idx_q);
  assign value     = gnd_pkg::NOTE_VALUE[tbl_idx];
  assign recip     = gnd_pkg::NOTE_RECIP[tbl_idx];
  assign prod      = gnd_pkg::PROD_W'(rest_q) * gnd_pkg::PROD_W'(recip);
  assign stock_sel = stock_q[idx_q];
  assign take      = (quot_q > gnd_pkg::AMOUNT_W'(stock_sel)) ? stock_sel
                                                              : quot_q[gnd_pkg::COUNT_W-1:0];
  assign nv        = gnd_pkg::NV_W'(take) * gnd_pkg::NV_W'(value);

  assign clear_counts = (cmd_i.status == gnd_pkg::ST_CANNOT) ||
                        (cmd_i.status == gnd_pkg::ST_INVALID);

  for (genvar k = 0; k < gnd_pkg::TABLE_SIZE; k++) begin : g_full
    if (k < NUM_USED) begin : g_used
      assign chosen_full[k] = chosen_q[k];
    end else begin : g_unused
      assign chosen_full[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      for (int k = 0; k < NUM_USED; k++) begin
        stock_q[k] <= gnd_pkg::STOCK_RESET[k];
      end
    end else begin
      if (cmd_i.load) begin
        idx_q <= IDX_TOP;
      end else if (cmd_i.sub) begin
        idx_q <= idx_q - 1'b1;
      end
      if (cmd_i.debit) begin
        for (int k = 0; k < NUM_USED; k++) begin
          stock_q[k] <= stock_q[k] - chosen_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rest_q   <= amount_i;
      commit_q <= commit_i;
      zero_q   <= (amount_i == '0);
      for (int k = 0; k < NUM_USED; k++) begin
        chosen_q[k] <= '0;
      end
    end
    if (cmd_i.mul) begin
      quot_q <= prod[gnd_pkg::RECIP_SHIFT +: gnd_pkg::AMOUNT_W];
    end
    if (cmd_i.clamp) begin
      nv_q            <= nv;
      chosen_q[idx_q] <= take;
    end
    if (cmd_i.sub) begin
      rest_q <= rest_q - gnd_pkg::AMOUNT_W'(nv_q);
    end
    if (cmd_i.publish) begin
      status_q <= cmd_i.status;
      notes_q  <= clear_counts ? '0 : chosen_full;
    end
  end

  assign sts_o.last        = (idx_q == '0);
  assign sts_o.rest_zero   = (rest_q == '0);
  assign sts_o.amount_zero = zero_q;
  assign sts_o.commit      = commit_q;

  assign status_o = status_q;
  assign notes_o  = notes_q;

endmodule

// ===== rtl/gnd_ctrl.sv =====
// Controller of the note dispenser: sequences the per-note steps and the result handshake
module gnd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  gnd_pkg::sts_t sts_i,
  output gnd_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_CLAMP  = 3'd2;
  localparam logic [2:0] S_SUB    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic                         rsp_valid_q, rsp_valid_d;
  logic [gnd_pkg::STATUS_W-1:0] status;

  always_comb begin
    if (sts_i.amount_zero) begin
      status = gnd_pkg::ST_INVALID;
    end else if (!sts_i.rest_zero) begin
      status = gnd_pkg::ST_CANNOT;
    end else if (sts_i.commit) begin
      status = gnd_pkg::ST_DISPENSED;
    end else begin
      status = gnd_pkg::ST_QUOTED;
    end
  end

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.status = status;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CLAMP;
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = sts_i.last ? S_FINISH : S_MUL;
      end
      S_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.publish = 1'b1;
          cmd_o.debit   = (status == gnd_pkg::ST_DISPENSED);
          rsp_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

// ===== rtl/greedy_note_dispenser.sv =====
// Top level of the greedy note dispenser with limited stock
//
//   channel  direction  carries                         item taken when
//   req_i    in         amount, commit                  valid && ready
//   rsp_o    out        status, notes_450 .. notes_1    valid && ready
//
// A new request is taken only once the last item is published: each note
// value in use costs a reciprocal multiply, a clamp-and-multiply and a
// remainder subtract on the one shared datapath, then a publish step
// registers the result and debits stock if the notes are dispensed.
// Reset loads the stock with its initial counts at once; no sweep is needed.
// A result waiting on rsp_o does not block the next request; only the
// publish step waits for the output register to free up.
module greedy_note_dispenser #(
  parameter int unsigned NUM_NOTE_VALUES = gnd_pkg::NUM_NOTE_VALUES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gnd_req_if.sink     req_i,
  gnd_rsp_if.source   rsp_o
);

  localparam int unsigned NUM_USED = (NUM_NOTE_VALUES < gnd_pkg::TABLE_SIZE) ?
                                     NUM_NOTE_VALUES : gnd_pkg::TABLE_SIZE;

  gnd_pkg::cmd_t                                        cmd;
  gnd_pkg::sts_t                                        sts;
  logic                                                 req_ready;
  logic                                                 rsp_valid;
  logic [gnd_pkg::STATUS_W-1:0]                         status;
  logic [gnd_pkg::TABLE_SIZE-1:0][gnd_pkg::COUNT_W-1:0] notes;

  gnd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gnd_datapath #(
    .NUM_USED (NUM_USED)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .amount_i (req_i.amount),
    .commit_i (req_i.commit),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .status_o (status),
    .notes_o  (notes)
  );

  assign req_i.ready     = req_ready;
  assign rsp_o.valid     = rsp_valid;
  assign rsp_o.status    = status;
  assign rsp_o.notes_1   = notes[0];
  assign rsp_o.notes_2   = notes[1];
  assign rsp_o.notes_5   = notes[2];
  assign rsp_o.notes_10  = notes[3];
  assign rsp_o.notes_20  = notes[4];
  assign rsp_o.notes_50  = notes[5];
  assign rsp_o.notes_250 = notes[6];
  assign rsp_o.notes_450 = notes[7];

endmodule

// ===== rtl/gnd_checker.sv =====
// Port-level checker of the note dispenser and its bind to the top level
`include "greedy_note_dispenser_assert.svh"

module gnd_checker (
  input logic                                           clk_i,
  input logic                                           rst_ni,
  input logic                                           req_valid_i,
  input logic                                           req_ready_i,
  input logic                                           rsp_valid_i,
  input logic                                           rsp_ready_i,
  input logic [gnd_pkg::STATUS_W-1:0]                   rsp_status_i,
  input logic [gnd_pkg::TABLE_SIZE*gnd_pkg::COUNT_W-1:0] rsp_notes_i
);

  logic any_notes;
  logic failed;
  logic succeeded;

  assign any_notes = |rsp_notes_i;
  assign failed    = (rsp_status_i == gnd_pkg::ST_INVALID) ||
                     (rsp_status_i == gnd_pkg::ST_CANNOT);
  assign succeeded = (rsp_status_i == gnd_pkg::ST_DISPENSED) ||
                     (rsp_status_i == gnd_pkg::ST_QUOTED);

  `GND_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
                   rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_notes_i))

  `GND_ASSERT_NEXT(a_one_at_a_time, req_valid_i && req_ready_i, !req_ready_i)

  `GND_ASSERT_NOW(a_fail_no_notes, rsp_valid_i && failed, !any_notes)

  `GND_ASSERT_NOW(a_success_has_notes, rsp_valid_i && succeeded, any_notes)

endmodule

bind greedy_note_dispenser gnd_checker u_gnd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_notes_i  ({rsp_o.notes_450, rsp_o.notes_250, rsp_o.notes_50, rsp_o.notes_20,
                  rsp_o.notes_10, rsp_o.notes_5, rsp_o.notes_2, rsp_o.notes_1})
);
